/* sv/src_pkg.sv */
// Shared constants, state type and lookup tables of the stereo RMS compressor.
package src_pkg;

    localparam int SAMPLE_W  = 24;
    localparam int MAG_W     = SAMPLE_W - 1;
    localparam int TAB_SIZE  = 256;
    localparam int TAB_IDX_W = 8;
    localparam int GAIN_W    = 16;

    localparam logic signed [15:0] DB_FLOOR   = -16'sd30720;
    localparam logic [18:0]        DB_PER_OCT = 19'd394566;
    localparam logic [21:0]        OCT_PER_DB = 22'd2786635;
    localparam logic [22:0]        MAG_MAX    = 23'h7FFFFF;

    // Configuration register indexes
    localparam logic [2:0] REG_THRESHOLD  = 3'd0;
    localparam logic [2:0] REG_SLOPE      = 3'd1;
    localparam logic [2:0] REG_KNEE       = 3'd2;
    localparam logic [2:0] REG_KNEE_SCALE = 3'd3;
    localparam logic [2:0] REG_ATTACK     = 3'd4;
    localparam logic [2:0] REG_RELEASE    = 3'd5;

    typedef enum logic [4:0] {
        S_IDLE, S_SQL, S_SQR, S_SUM, S_SQRT, S_LVL,
        S_E1, S_E2, S_E3, S_NORM, S_LOG, S_DB, S_GAIN,
        S_K1, S_K2, S_K3, S_K4, S_K5, S_H1, S_H2,
        S_L1, S_L2, S_SHR, S_SL, S_SR, S_SAT, S_DONE
    } src_state_t;

    typedef logic [15:0] log_tab_t [TAB_SIZE];
    typedef logic [30:0] exp_tab_t [TAB_SIZE];

    // Integer square root, used only while building tables
    function automatic longint unsigned isqrt64(input longint unsigned v);
        longint unsigned res;
        longint unsigned bit_v;
        longint unsigned rem;
        res   = 0;
        bit_v = 64'h4000_0000_0000_0000;
        rem   = v;
        while (bit_v > rem) bit_v = bit_v >> 2;
        while (bit_v != 0) begin
            if (rem >= res + bit_v) begin
                rem = rem - (res + bit_v);
                res = (res >> 1) + bit_v;
            end else begin
                res = res >> 1;
            end
            bit_v = bit_v >> 2;
        end
        return res;
    endfunction

    // log2(1 + i/N) in Q16 by repeated squaring
    function automatic log_tab_t build_log_tab();
        log_tab_t        t;
        longint unsigned x;
        longint unsigned r;
        for (int i = 0; i < TAB_SIZE; i++) begin
            x = ((longint'(TAB_SIZE) + longint'(i)) << 30) / TAB_SIZE;
            r = 0;
            for (int k = 0; k < 16; k++) begin
                x = (x * x) >> 30;
                r = r << 1;
                if (x >= (64'd1 << 31)) begin
                    r = r | 64'd1;
                    x = x >> 1;
                end
            end
            t[i] = r[15:0];
        end
        return t;
    endfunction

    // 2^(i/N) in Q1.30 as a product of square roots of two
    function automatic exp_tab_t build_exp_tab();
        exp_tab_t        t;
        longint unsigned roots [17];
        longint unsigned f;
        longint unsigned acc;
        roots[0] = 64'd1 << 31;
        for (int k = 1; k <= 16; k++) roots[k] = isqrt64(roots[k-1] << 30);
        for (int i = 0; i < TAB_SIZE; i++) begin
            f   = (longint'(i) << 16) / TAB_SIZE;
            acc = 64'd1 << 30;
            for (int k = 1; k <= 16; k++) begin
                if (((f >> (16 - k)) & 64'd1) != 0) acc = (acc * roots[k]) >> 30;
            end
            t[i] = acc[30:0];
        end
        return t;
    endfunction

    localparam log_tab_t LOG_TAB = build_log_tab();
    localparam exp_tab_t EXP_TAB = build_exp_tab();

    // Clamp a gain in Q8.8 dB to [floor, 0]
    function automatic logic signed [15:0] clamp_gain(input logic signed [23:0] v);
        logic signed [15:0] r;
        if (v > 24'sd0)                          r = 16'sd0;
        else if (v < 24'(DB_FLOOR))              r = DB_FLOOR;
        else                                     r = v[15:0];
        return r;
    endfunction

    // Round half up at bit 30 and saturate to one sample
    function automatic logic [23:0] sat_sample(input logic signed [57:0] p);
        logic signed [57:0] t;
        logic signed [27:0] v;
        logic [23:0]        r;
        t = p + 58'sd536870912;
        v = t[57:30];
        if (v > 28'sd8388607)       r = 24'h7FFFFF;
        else if (v < -28'sd8388608) r = 24'h800000;
        else                        r = v[23:0];
        return r;
    endfunction

endpackage

/* sv/src_isqrt.sv */
// Bit-serial integer square root: one result bit per cycle.
module src_isqrt
    import src_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [47:0] rad_in,
    output logic        done,
    output logic [23:0] root
);

    logic [47:0] rad_reg;
    logic [25:0] rem_reg;
    logic [23:0] root_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [27:0] rem_t;
    logic [27:0] trial;
    logic        ge;

    // Trial subtraction of the next bit pair
    always_comb begin
        rem_t = {rem_reg, rad_reg[47:46]};
        trial = {2'b00, root_reg, 2'b01};
        ge    = rem_t >= trial;
    end

    // Advance one digit per cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'd23;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rad_reg  <= rad_in;
            rem_reg  <= 26'd0;
            root_reg <= 24'd0;
        end else if (busy_reg) begin
            rad_reg  <= {rad_reg[45:0], 2'b00};
            rem_reg  <= ge ? 26'(rem_t - trial) : rem_t[25:0];
            root_reg <= {root_reg[22:0], ge};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

/* sv/stereo_rms_compressor.sv */
// Top level: stereo feed-forward RMS compressor with soft knee.
//
//  Port group | Dir  | Beat contents
//  s_*        | in   | left_in, right_in samples
//  m_*        | out  | left_out, right_out, gain_reduction_db
//  APB        | in   | six configuration registers at 4*i
//
// A result reaches the output register after a bit-serial square root,
// a normalize shift for the log lookup, a linear gain shift, and up to
// 12 shared multiplier passes. The sequencer then returns to idle, where
// the next frame is taken.
// Reset clears the envelope and the output valid and sets the configuration to its defaults.
// A new frame is taken once the sequencer is back in idle; a finished
// result waits in the output register and does not hold the sequencer
// until the next result is ready.
module stereo_rms_compressor
    import src_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // left_in[23:0], right_in[47:24]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // left_out[23:0], right_out[47:24], gain[63:48]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    src_state_t state_reg, state_next;

    logic signed [15:0] thr_reg;
    logic signed [15:0] slope_reg;
    logic [12:0]        knee_reg;
    logic [15:0]        ks_reg;
    logic [15:0]        atk_reg;
    logic [15:0]        rel_reg;

    logic signed [23:0] l_reg, r_reg;
    logic signed [59:0] acc_reg;
    logic signed [57:0] prod_reg;
    logic signed [57:0] prod_next;
    logic signed [32:0] mul_a;
    logic signed [24:0] mul_b;
    logic [22:0]        level_reg;
    logic [16:0]        coef_reg;
    logic [22:0]        env_reg;
    logic [22:0]        mant_reg;
    logic [4:0]         cnt_reg;
    logic signed [15:0] db_reg;
    logic [12:0]        x_reg;
    logic signed [15:0] gain_reg;
    logic [30:0]        gl_reg;
    logic [23:0]        lo_reg, ro_reg;
    logic               m_tvalid_reg;
    logic [63:0]        m_tdata_reg;

    logic        sqrt_start;
    logic        sqrt_done;
    logic [23:0] sqrt_root;
    logic [47:0] sum_sq;
    logic [22:0] lvl;
    logic [39:0] env_sum;
    logic [22:0] env_new;
    logic signed [6:0]  neg_oct;
    logic signed [22:0] l2;
    logic signed [33:0] dbw;
    logic signed [17:0] db18, thr18, half18, lo18, hi18, edge18;
    logic               in_knee, above;
    logic signed [59:0] total;
    logic signed [5:0]  ip;
    logic [5:0]         sh;
    logic               out_free;
    logic               cfg_wr;

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg   <= -16'sd5120;
            slope_reg <= 16'sd0;
            knee_reg  <= 13'd0;
            ks_reg    <= 16'd0;
            atk_reg   <= 16'd0;
            rel_reg   <= 16'd0;
        end else if (cfg_wr) begin
            unique case (paddr[4:2])
                REG_THRESHOLD:  thr_reg   <= pwdata[15:0];
                REG_SLOPE:      slope_reg <= pwdata[15:0];
                REG_KNEE:       knee_reg  <= pwdata[12:0];
                REG_KNEE_SCALE: ks_reg    <= pwdata[15:0];
                REG_ATTACK:     atk_reg   <= pwdata[15:0];
                REG_RELEASE:    rel_reg   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_THRESHOLD:  prdata = {16'd0, thr_reg};
            REG_SLOPE:      prdata = {16'd0, slope_reg};
            REG_KNEE:       prdata = {19'd0, knee_reg};
            REG_KNEE_SCALE: prdata = {16'd0, ks_reg};
            REG_ATTACK:     prdata = {16'd0, atk_reg};
            REG_RELEASE:    prdata = {16'd0, rel_reg};
            default:        prdata = 32'd0;
        endcase
    end

    // Square root unit
    assign sum_sq = acc_reg[47:0] + prod_reg[47:0];

    src_isqrt u_isqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sqrt_start),
        .rad_in  ({1'b0, sum_sq[47:1]}),
        .done    (sqrt_done),
        .root    (sqrt_root)
    );

    // Datapath helpers
    always_comb begin
        lvl     = sqrt_root[23] ? MAG_MAX : sqrt_root[22:0];
        env_sum = acc_reg[39:0] + prod_reg[39:0] + 40'd32768;
        env_new = env_sum[38:16];
        neg_oct = 7'sd0 - 7'(cnt_reg) - 7'sd1;
        l2      = {neg_oct, LOG_TAB[mant_reg[21:14]]};
        dbw     = prod_reg[57:24];
        db18    = 18'(db_reg);
        thr18   = 18'(thr_reg);
        half18  = {6'd0, knee_reg[12:1]};
        lo18    = thr18 - half18;
        hi18    = thr18 + half18;
        edge18  = (knee_reg != 13'd0) ? hi18 : thr18;
        in_knee = (knee_reg != 13'd0) && (db18 >= lo18) && (db18 <= hi18);
        above   = db18 > edge18;
        total   = (60'(prod_reg) <<< 21) + acc_reg;
        ip      = prod_reg[37:32];
        sh      = 6'd0 - 6'(ip);
        out_free = !m_tvalid_reg || m_tready;
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (s_tvalid) state_next = S_SQL;
            S_SQL:  state_next = S_SQR;
            S_SQR:  state_next = S_SUM;
            S_SUM:  state_next = S_SQRT;
            S_SQRT: if (sqrt_done) state_next = S_LVL;
            S_LVL:  state_next = S_E1;
            S_E1:   state_next = S_E2;
            S_E2:   state_next = S_E3;
            S_E3:   state_next = (env_new == 23'd0) ? S_GAIN : S_NORM;
            S_NORM: if (mant_reg[22]) state_next = S_LOG;
            S_LOG:  state_next = S_DB;
            S_DB:   state_next = S_GAIN;
            S_GAIN: begin
                if (in_knee)    state_next = S_K1;
                else if (above) state_next = S_H1;
                else            state_next = S_L1;
            end
            S_K1:   state_next = S_K2;
            S_K2:   state_next = S_K3;
            S_K3:   state_next = S_K4;
            S_K4:   state_next = S_K5;
            S_K5:   state_next = S_L1;
            S_H1:   state_next = S_H2;
            S_H2:   state_next = S_L1;
            S_L1:   state_next = S_L2;
            S_L2:   state_next = S_SHR;
            S_SHR:  if (cnt_reg == 5'd0) state_next = S_SL;
            S_SL:   state_next = S_SR;
            S_SR:   state_next = S_SAT;
            S_SAT:  state_next = S_DONE;
            S_DONE: if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Sequencer outputs: handshake, root start, multiplier operands
    always_comb begin
        s_tready   = 1'b0;
        sqrt_start = 1'b0;
        mul_a      = 33'sd0;
        mul_b      = 25'sd0;
        unique case (state_reg)
            S_IDLE: s_tready = 1'b1;
            S_SQL: begin
                mul_a = 33'(l_reg);
                mul_b = 25'(l_reg);
            end
            S_SQR: begin
                mul_a = 33'(r_reg);
                mul_b = 25'(r_reg);
            end
            S_SUM: sqrt_start = 1'b1;
            S_E1: begin
                mul_a = {10'd0, env_reg};
                mul_b = {8'd0, coef_reg};
            end
            S_E2: begin
                mul_a = {10'd0, level_reg};
                mul_b = {8'd0, 17'(17'h10000 - coef_reg)};
            end
            S_LOG: begin
                mul_a = 33'(l2);
                mul_b = {6'd0, DB_PER_OCT};
            end
            S_K1: begin
                mul_a = {20'd0, x_reg};
                mul_b = {12'd0, x_reg};
            end
            S_K2: begin
                mul_a = {7'd0, prod_reg[25:0]};
                mul_b = {9'd0, ks_reg};
            end
            S_K3: begin
                mul_a = {12'd0, prod_reg[20:0]};
                mul_b = 25'(slope_reg);
            end
            S_K4: begin
                mul_a = {12'd0, acc_reg[20:0]};
                mul_b = 25'(slope_reg);
            end
            S_H1: begin
                mul_a = 33'(db18 - thr18);
                mul_b = 25'(slope_reg);
            end
            S_L1: begin
                mul_a = {11'd0, OCT_PER_DB};
                mul_b = 25'(gain_reg);
            end
            S_SL: begin
                mul_a = {2'd0, gl_reg};
                mul_b = 25'(l_reg);
            end
            S_SR: begin
                mul_a = {2'd0, gl_reg};
                mul_b = 25'(r_reg);
            end
            default: ;
        endcase
    end

    assign prod_next = mul_a * mul_b;

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            env_reg      <= 23'd0;
            gain_reg     <= 16'sd0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_E3) env_reg <= env_new;
            if (state_reg == S_GAIN && !in_knee && !above) gain_reg <= 16'sd0;
            if (state_reg == S_K5) gain_reg <= clamp_gain(24'($signed(total[59:39])));
            if (state_reg == S_H2) gain_reg <= clamp_gain(prod_reg[38:15]);
            if (state_reg == S_DONE && out_free) m_tvalid_reg <= 1'b1;
            else if (m_tready)                   m_tvalid_reg <= 1'b0;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        case (state_reg)
            S_IDLE: begin
                l_reg <= s_tdata[23:0];
                r_reg <= s_tdata[47:24];
            end
            S_SQR: acc_reg <= 60'(prod_reg);
            S_LVL: begin
                level_reg <= lvl;
                coef_reg  <= {1'b0, (lvl > env_reg) ? atk_reg : rel_reg};
            end
            S_E2: acc_reg <= 60'(prod_reg);
            S_E3: begin
                mant_reg <= env_new;
                cnt_reg  <= 5'd0;
                db_reg   <= DB_FLOOR;
            end
            S_NORM: begin
                if (!mant_reg[22]) begin
                    mant_reg <= {mant_reg[21:0], 1'b0};
                    cnt_reg  <= cnt_reg + 5'd1;
                end
            end
            S_DB: db_reg <= (dbw < 34'(DB_FLOOR)) ? DB_FLOOR : dbw[15:0];
            S_GAIN: x_reg <= 13'(db18 - lo18);
            S_K3: acc_reg <= {39'd0, prod_reg[41:21]};
            S_K4: acc_reg <= 60'(prod_reg);
            S_L2: begin
                gl_reg  <= EXP_TAB[prod_reg[31:24]];
                cnt_reg <= sh[4:0];
            end
            S_SHR: begin
                if (cnt_reg != 5'd0) begin
                    gl_reg  <= {1'b0, gl_reg[30:1]};
                    cnt_reg <= cnt_reg - 5'd1;
                end
            end
            S_SR:  lo_reg <= sat_sample(prod_reg);
            S_SAT: ro_reg <= sat_sample(prod_reg);
            S_DONE: if (out_free) m_tdata_reg <= {gain_reg, ro_reg, lo_reg};
            default: ;
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Applied gain always lies in the dB range
    a_gain_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (gain_reg <= 16'sd0) && (gain_reg >= DB_FLOOR))
        else $error("gain out of range");

    // The log lookup only sees a normalized mantissa
    a_norm: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_LOG) |-> mant_reg[22])
        else $error("mantissa not normalized");

    // No result right after a frame is taken
    a_no_early: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !$rose(m_tvalid_reg))
        else $error("result too early");

    // A new result carries the current gain
    a_gain_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> (m_tdata_reg[63:48] == gain_reg))
        else $error("gain field mismatch");

endmodule
